// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define LRTC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define LRTC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LRTC_ASSERT(lbl, clk, rst, prop, msg)
`define LRTC_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== sv/lrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrtc_pkg
// Constants, jump tables, state and control types of the LCG tile column core.
// ----------------------------------------------------------------------------
package lrtc_pkg;

   localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
   localparam logic [63:0] LCG_INC = 64'd1;

   localparam int TILE_ROWS = 64;

   localparam int ROW_W   = 31;
   localparam int COL_W   = 31;
   localparam int COFF_W  = 6;
   localparam int CNT_W   = 7;
   localparam int STATE_W = 64;
   localparam int VALUE_W = 33;
   localparam int IDX_W   = 6;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // request field positions inside req_tdata
   localparam int ROW_LSB  = 0;
   localparam int COL_LSB  = ROW_LSB + ROW_W;
   localparam int COFF_LSB = COL_LSB + COL_W;
   localparam int CNT_LSB  = COFF_LSB + COFF_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_ROWS = 2'd1;

   localparam logic [63:0]      SEED_RESET = 64'd3872;
   localparam logic [ROW_W-1:0] ROWS_RESET = 31'd1000;

   typedef logic [63:0] coef_tab_type [64];

   // multiplier for bit k of the jump: LCG_MUL^(2^k)
   function automatic coef_tab_type build_mul_tab();
      coef_tab_type t;
      logic [63:0]  m;
      m = LCG_MUL;
      for (int k = 0; k < 64; k++) begin
         t[k] = m;
         m    = m * m;
      end
      return t;
   endfunction

   // increment for bit k of the jump
   function automatic coef_tab_type build_add_tab();
      coef_tab_type t;
      logic [63:0]  m;
      logic [63:0]  a;
      m = LCG_MUL;
      a = LCG_INC;
      for (int k = 0; k < 64; k++) begin
         t[k] = a;
         a    = a * (m + 64'd1);
         m    = m * m;
      end
      return t;
   endfunction

   localparam coef_tab_type MUL_TAB = build_mul_tab();
   localparam coef_tab_type ADD_TAB = build_add_tab();

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_POS,
      ST_JUMP,
      ST_JUMP_ACC,
      ST_EMIT,
      ST_EMIT_ACC
   } state_type;

   typedef struct packed {
      logic capture;
      logic calc_prod;
      logic load_pos;
      logic mult;
      logic sel_step;
      logic accum;
      logic shift_pos;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic pos_zero;
      logic pos_bit;
      logic cnt_zero;
      logic cnt_one;
      logic out_free;
   } sts_type;

endpackage

// ===== sv/lcg_random_tile_column_core.sv =====
// ----------------------------------------------------------------------------
// lcg_random_tile_column_core
// Generates one column of a pseudo-random tile from a jumped 64-bit LCG.
// ----------------------------------------------------------------------------
// Usage: write seed (index 0) and global_rows (index 1) on the csr channel
// while idle. Each request on req_ names a tile column; the core forms
// pos = tile_row0 + (tile_col0 + col_offset) * global_rows, jumps the
// generator from the seed by pos steps, then returns row_count results on
// rsp_ (row_count saturates at 64, zero gives no result), tlast on the final.
// Sequence: capture and setup of the product and pos, then the jump walks pos
// from bit 0 up to its highest set bit, only shifting on a clear bit and
// multiplying then accumulating on a set bit (pos stays below 2^62 + 2^37),
// on the two-stage 64-bit multiply built from three 32x32 partial products.
// Each element then uses the same multiplier, with no multiply for the last;
// the core takes no new request while an item is in progress, and the next
// request is taken the cycle after the last result is loaded.
// A single output register holds a result while the receiver stalls; the
// sequencer waits there and resumes when the result is taken.
// Reset restores seed 3872 and global_rows 1000 and empties the output.
// ----------------------------------------------------------------------------
module lcg_random_tile_column_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata: tile_row0[30:0], tile_col0[61:31], col_offset[67:62],
   //            row_count[74:68], zero fill up to bit 79
   input  logic [lrtc_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: value[32:0], raw_state[96:33], zero fill up to bit 103
   output logic [lrtc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lrtc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lrtc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   lrtc_pkg::cmd_type cmd;
   lrtc_pkg::sts_type sts;
   logic              csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   lrtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lrtc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/lrtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrtc_ctrl
// Sequencer: position setup, bitwise jump-ahead, then one element per step.
// ----------------------------------------------------------------------------
module lrtc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output lrtc_pkg::cmd_type cmd,
   input  lrtc_pkg::sts_type sts
);

   lrtc_pkg::state_type state_ff;
   lrtc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrtc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrtc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lrtc_pkg::ST_PROD;
         end
         lrtc_pkg::ST_PROD: begin
            state_in = lrtc_pkg::ST_POS;
         end
         lrtc_pkg::ST_POS: begin
            state_in = lrtc_pkg::ST_JUMP;
         end
         lrtc_pkg::ST_JUMP: begin
            if (sts.pos_zero) state_in = lrtc_pkg::ST_EMIT;
            else if (sts.pos_bit) state_in = lrtc_pkg::ST_JUMP_ACC;
         end
         lrtc_pkg::ST_JUMP_ACC: begin
            state_in = lrtc_pkg::ST_JUMP;
         end
         lrtc_pkg::ST_EMIT: begin
            if (sts.cnt_zero) state_in = lrtc_pkg::ST_IDLE;
            else if (sts.out_free) begin
               state_in = sts.cnt_one ? lrtc_pkg::ST_IDLE : lrtc_pkg::ST_EMIT_ACC;
            end
         end
         lrtc_pkg::ST_EMIT_ACC: begin
            state_in = lrtc_pkg::ST_EMIT;
         end
         default: begin
            state_in = lrtc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lrtc_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         lrtc_pkg::ST_PROD: begin
            cmd.calc_prod = 1'b1;
         end
         lrtc_pkg::ST_POS: begin
            cmd.load_pos = 1'b1;
         end
         lrtc_pkg::ST_JUMP: begin
            // set bit: multiply now, accumulate next; clear bit: just advance
            if (!sts.pos_zero) begin
               if (sts.pos_bit) cmd.mult = 1'b1;
               else cmd.shift_pos = 1'b1;
            end
         end
         lrtc_pkg::ST_JUMP_ACC: begin
            cmd.accum     = 1'b1;
            cmd.shift_pos = 1'b1;
         end
         lrtc_pkg::ST_EMIT: begin
            if (!sts.cnt_zero && sts.out_free) begin
               cmd.load_out = 1'b1;
               if (!sts.cnt_one) begin
                  cmd.mult     = 1'b1;
                  cmd.sel_step = 1'b1;
               end
            end
         end
         lrtc_pkg::ST_EMIT_ACC: begin
            cmd.accum = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/lrtc_dpath.sv =====
// ----------------------------------------------------------------------------
// lrtc_dpath
// Settings, position arithmetic, split 64-bit LCG multiplier and result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrtc_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lrtc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               csr_write,
   input  logic [lrtc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lrtc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  lrtc_pkg::cmd_type                  cmd,
   output lrtc_pkg::sts_type                  sts,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lrtc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);

   logic [63:0]                       seed_ff, seed_in;
   logic [lrtc_pkg::ROW_W-1:0]        grows_ff, grows_in;
   logic [lrtc_pkg::ROW_W-1:0]        row0_ff, row0_in;
   logic [31:0]                       colsum_ff, colsum_in;
   logic [lrtc_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [62:0]                       prod_ff, prod_in;
   logic [63:0]                       pos_ff, pos_in;
   logic [lrtc_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [63:0]                       x_ff, x_in;
   logic [63:0]                       plo_ff, plo_in;
   logic [31:0]                       px1_ff, px1_in;
   logic [31:0]                       px2_ff, px2_in;
   logic [63:0]                       addend_ff, addend_in;
   logic [lrtc_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic [lrtc_pkg::STATE_W-1:0]      raw_ff, raw_in;
   logic                              last_ff, last_in;
   logic                              valid_ff, valid_in;

   logic [lrtc_pkg::ROW_W-1:0]        req_row0;
   logic [lrtc_pkg::COL_W-1:0]        req_col0;
   logic [lrtc_pkg::COFF_W-1:0]       req_coff;
   logic [lrtc_pkg::CNT_W-1:0]        req_cnt;
   logic [63:0]                       coef;
   logic [63:0]                       addend_sel;

   assign req_row0 = req_tdata[lrtc_pkg::ROW_LSB +: lrtc_pkg::ROW_W];
   assign req_col0 = req_tdata[lrtc_pkg::COL_LSB +: lrtc_pkg::COL_W];
   assign req_coff = req_tdata[lrtc_pkg::COFF_LSB +: lrtc_pkg::COFF_W];
   assign req_cnt  = req_tdata[lrtc_pkg::CNT_LSB +: lrtc_pkg::CNT_W];

   assign coef       = cmd.sel_step ? lrtc_pkg::LCG_MUL : lrtc_pkg::MUL_TAB[idx_ff];
   assign addend_sel = cmd.sel_step ? lrtc_pkg::LCG_INC : lrtc_pkg::ADD_TAB[idx_ff];

   always_comb begin
      seed_in   = seed_ff;
      grows_in  = grows_ff;
      row0_in   = row0_ff;
      colsum_in = colsum_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      x_in      = x_ff;
      plo_in    = plo_ff;
      px1_in    = px1_ff;
      px2_in    = px2_ff;
      addend_in = addend_ff;
      value_in  = value_ff;
      raw_in    = raw_ff;
      last_in   = last_ff;
      valid_in  = valid_ff;

      if (csr_write) begin
         if (csr_index == lrtc_pkg::CSR_SEED) seed_in = csr_wdata;
         else if (csr_index == lrtc_pkg::CSR_GLOBAL_ROWS) begin
            grows_in = csr_wdata[lrtc_pkg::ROW_W-1:0];
         end
      end

      if (cmd.capture) begin
         row0_in   = req_row0;
         colsum_in = {1'b0, req_col0} + {26'd0, req_coff};
         cnt_in    = (req_cnt > lrtc_pkg::CNT_W'(lrtc_pkg::TILE_ROWS)) ?
                     lrtc_pkg::CNT_W'(lrtc_pkg::TILE_ROWS) : req_cnt;
         x_in      = seed_ff;
         idx_in    = '0;
      end

      if (cmd.calc_prod) prod_in = colsum_ff * grows_ff;
      if (cmd.load_pos) pos_in = {1'b0, prod_ff} + {33'd0, row0_ff};

      // drop the consumed position bit
      if (cmd.shift_pos) begin
         pos_in = pos_ff >> 1;
         idx_in = idx_ff + 1'b1;
      end

      // partial products of the low 64 bits of x * coef
      if (cmd.mult) begin
         plo_in    = x_ff[31:0] * coef[31:0];
         px1_in    = x_ff[31:0] * coef[63:32];
         px2_in    = x_ff[63:32] * coef[31:0];
         addend_in = addend_sel;
      end

      if (cmd.accum) x_in = plo_ff + {px1_ff + px2_ff, 32'd0} + addend_ff;

      if (cmd.load_out) begin
         value_in = {1'b0, 32'h8000_0000} - {1'b0, x_ff[63:32]};
         raw_in   = x_ff;
         last_in  = sts.cnt_one;
         cnt_in   = cnt_ff - 1'b1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= lrtc_pkg::SEED_RESET;
         grows_ff <= lrtc_pkg::ROWS_RESET;
         valid_ff <= 1'b0;
      end else begin
         seed_ff  <= seed_in;
         grows_ff <= grows_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row0_ff   <= row0_in;
      colsum_ff <= colsum_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      x_ff      <= x_in;
      plo_ff    <= plo_in;
      px1_ff    <= px1_in;
      px2_ff    <= px2_in;
      addend_ff <= addend_in;
      value_ff  <= value_in;
      raw_ff    <= raw_in;
      last_ff   <= last_in;
   end

   assign sts.pos_zero = (pos_ff == '0);
   assign sts.pos_bit  = pos_ff[0];
   assign sts.cnt_zero = (cnt_ff == '0);
   assign sts.cnt_one  = (cnt_ff == lrtc_pkg::CNT_W'(1));
   assign sts.out_free = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, raw_ff, value_ff};
   assign rsp_tlast  = last_ff;

   `LRTC_ASSERT(a_accum_after_mult, clock, reset, cmd.accum |-> $past(cmd.mult), "accumulate without products")
   `LRTC_ASSERT(a_last_empties_count, clock, reset, (cmd.load_out && sts.cnt_one) |=> sts.cnt_zero, "count left after last element")
   `LRTC_ASSERT_NEVER(a_load_on_empty, clock, reset, cmd.load_out && sts.cnt_zero, "element emitted with zero count")
   `LRTC_ASSERT_NEVER(a_overwrite_out, clock, reset, cmd.load_out && valid_ff && !rsp_tready, "result overwritten while stalled")

endmodule

// ===== tb/tb_lcg_random_tile_column_core.sv =====
// ----------------------------------------------------------------------------
// tb_lcg_random_tile_column_core
// Streams tile column requests into the core under random valid/ready gaps,
// predicts every element from a jumped 64-bit LCG mirror, and checks each
// returned element in order. Seed and global_rows are rewritten between
// phases while the core is idle, extremes included.
// ----------------------------------------------------------------------------
module tb_lcg_random_tile_column_core;

   localparam int SETTLE = 200;   // quiet cycles before a csr write and at the end

   typedef enum logic {JOB_COLUMN, JOB_WRITE} job_kind_type;

   typedef struct {
      job_kind_type                        kind;
      logic [lrtc_pkg::ROW_W-1:0]          row0;
      logic [lrtc_pkg::COL_W-1:0]          col0;
      logic [lrtc_pkg::COFF_W-1:0]         coff;
      logic [lrtc_pkg::CNT_W-1:0]          cnt;
      logic [lrtc_pkg::CSR_IDX_W-1:0]      reg_idx;
      logic [lrtc_pkg::CSR_DATA_W-1:0]     wval;
   } job_type;

   typedef struct {
      logic [lrtc_pkg::VALUE_W-1:0]  value;
      logic [lrtc_pkg::STATE_W-1:0]  state;
      logic                          last;
   } element_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [lrtc_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [lrtc_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                rsp_tlast;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [lrtc_pkg::CSR_IDX_W-1:0]      csr_index = lrtc_pkg::CSR_SEED;
   logic [lrtc_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   job_type       work_q[$];
   element_type   element_q[$];
   job_type       cur_job;
   logic [63:0]   seed_m = lrtc_pkg::SEED_RESET;
   logic [30:0]   rows_m = lrtc_pkg::ROWS_RESET;
   bit            req_busy = 1'b0;
   bit            csr_busy = 1'b0;
   bit            req_calm = 1'b0;
   bit            rsp_calm = 1'b0;
   int            req_gap = 0;
   int            rsp_wait = 0;
   int            quiet = 0;
   int            errors = 0;

   lcg_random_tile_column_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int draw_pause(input bit calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // advance state x by n steps, squaring the step pair once per bit of n
   function automatic logic [63:0] lcg_leap(input logic [63:0] x, input logic [63:0] n);
      logic [63:0] m;
      logic [63:0] a;
      m = lrtc_pkg::LCG_MUL;
      a = lrtc_pkg::LCG_INC;
      for (int b = 0; b < 64; b++) begin
         if (n[b]) x = m * x + a;
         a = a * (m + 64'd1);
         m = m * m;
      end
      return x;
   endfunction

   function automatic void predict_column(input job_type j);
      logic [63:0]  pos;
      logic [63:0]  x;
      int           n;
      element_type  e;
      n = (j.cnt > lrtc_pkg::TILE_ROWS) ? lrtc_pkg::TILE_ROWS : int'(j.cnt);
      pos = 64'(j.row0) + (64'(j.col0) + 64'(j.coff)) * 64'(rows_m);
      x = lcg_leap(seed_m, pos);
      for (int k = 0; k < n; k++) begin
         e.value = 33'h0_8000_0000 - {1'b0, x[63:32]};
         e.state = x;
         e.last  = (k == n - 1);
         element_q.push_back(e);
         x = lrtc_pkg::LCG_MUL * x + lrtc_pkg::LCG_INC;
      end
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic add_column(input logic [30:0] row0, input logic [30:0] col0,
                             input logic [5:0] coff, input logic [6:0] cnt);
      job_type j;
      j.kind    = JOB_COLUMN;
      j.row0    = row0;
      j.col0    = col0;
      j.coff    = coff;
      j.cnt     = cnt;
      j.reg_idx = lrtc_pkg::CSR_SEED;
      j.wval    = '0;
      work_q.push_back(j);
   endtask

   task automatic add_write(input logic [lrtc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] val);
      job_type j;
      j.kind    = JOB_WRITE;
      j.row0    = '0;
      j.col0    = '0;
      j.coff    = '0;
      j.cnt     = '0;
      j.reg_idx = idx;
      j.wval    = val;
      work_q.push_back(j);
   endtask

   // driver: requests and csr writes, csr writes only once the core has gone quiet
   always @(posedge clock) begin
      if (reset) begin
         req_busy = 1'b0;
         csr_busy = 1'b0;
         req_gap  = 0;
         quiet    = 0;
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_column(cur_job);
            req_busy = 1'b0;
            if ($urandom_range(0, 39) == 0) req_calm = ~req_calm;
            req_gap = draw_pause(req_calm);
         end
         if (csr_valid && csr_ready) begin
            if (cur_job.reg_idx == lrtc_pkg::CSR_SEED)
               seed_m = cur_job.wval;
            else if (cur_job.reg_idx == lrtc_pkg::CSR_GLOBAL_ROWS)
               rows_m = cur_job.wval[30:0];
            csr_busy = 1'b0;
            req_gap  = draw_pause(req_calm);
         end
         if (req_busy || element_q.size() != 0)
            quiet = 0;
         else if (quiet < SETTLE)
            quiet++;
         if (!req_busy && !csr_busy && work_q.size() != 0) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (work_q[0].kind == JOB_COLUMN) begin
               cur_job  = work_q.pop_front();
               req_busy = 1'b1;
               req_tdata <= {5'b0, cur_job.cnt, cur_job.coff, cur_job.col0, cur_job.row0};
            end else if (quiet >= SETTLE) begin
               cur_job  = work_q.pop_front();
               csr_busy = 1'b1;
               csr_index <= cur_job.reg_idx;
               csr_wdata <= cur_job.wval;
            end
         end
         req_tvalid <= req_busy;
         csr_valid  <= csr_busy;
      end
   end

   // monitor: check each element against the oldest prediction, then stall at random
   always @(posedge clock) begin
      element_type want;
      if (reset) begin
         rsp_wait = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (element_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected element state=%h", rsp_tdata[96:33]));
            end else begin
               want = element_q.pop_front();
               if (rsp_tdata[32:0] !== want.value)
                  flag_mismatch($sformatf("value %h, want %h", rsp_tdata[32:0], want.value));
               if (rsp_tdata[96:33] !== want.state)
                  flag_mismatch($sformatf("raw_state %h, want %h", rsp_tdata[96:33],
                                          want.state));
               if (rsp_tlast !== want.last)
                  flag_mismatch($sformatf("last %b, want %b", rsp_tlast, want.last));
            end
            if ($urandom_range(0, 39) == 0) rsp_calm = ~rsp_calm;
            rsp_wait = draw_pause(rsp_calm);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   initial begin
      logic [30:0] r;
      logic [30:0] c;
      logic [6:0]  n;
      int          pick;

      // directed: reset configuration
      add_column(31'd0, 31'd0, 6'd0, 7'd1);
      add_column(31'd5, 31'd3, 6'd2, 7'd0);
      add_column(31'h7FFF_FFFF, 31'h7FFF_FFFF, 6'd63, 7'd64);
      add_column(31'd0, 31'd0, 6'd0, 7'd127);
      add_column(31'd1, 31'd0, 6'd0, 7'd65);
      add_column(31'h7FFF_FFFF, 31'd0, 6'd0, 7'd3);
      add_column(31'd0, 31'h7FFF_FFFF, 6'd0, 7'd2);
      add_column(31'd0, 31'd0, 6'd63, 7'd2);
      add_column(31'h5555_5555, 31'h2AAA_AAAA, 6'h2A, 7'h55);
      add_column(31'h2AAA_AAAA, 31'h5555_5555, 6'h15, 7'h2A);
      // directed: seed and stride at their top
      add_write(lrtc_pkg::CSR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
      add_write(lrtc_pkg::CSR_GLOBAL_ROWS, 64'h0000_0000_7FFF_FFFF);
      add_column(31'd0, 31'd0, 6'd0, 7'd4);
      add_column(31'h7FFF_FFFF, 31'h7FFF_FFFF, 6'd63, 7'd64);
      add_column(31'd1, 31'd1, 6'd1, 7'd0);
      add_column(31'd12345, 31'd678, 6'd9, 7'd7);
      // directed: zero stride maps every column onto the same start
      add_write(lrtc_pkg::CSR_SEED, 64'd0);
      add_write(lrtc_pkg::CSR_GLOBAL_ROWS, 64'hFFFF_FFFF_8000_0000);
      add_column(31'd0, 31'd0, 6'd0, 7'd3);
      add_column(31'd0, 31'h7FFF_FFFF, 6'd63, 7'd3);
      add_column(31'd7, 31'd99, 6'd5, 7'd66);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               add_write(lrtc_pkg::CSR_SEED, 64'd0);
               add_write(lrtc_pkg::CSR_GLOBAL_ROWS, 64'd1);
            end
            1: begin
               add_write(lrtc_pkg::CSR_SEED, lrtc_pkg::SEED_RESET);
               add_write(lrtc_pkg::CSR_GLOBAL_ROWS,
                         {$urandom, 1'b0, lrtc_pkg::ROWS_RESET});
            end
            default: begin
               add_write(lrtc_pkg::CSR_SEED, {$urandom, $urandom});
               if (ph % 2 == 0)
                  add_write(lrtc_pkg::CSR_GLOBAL_ROWS, {$urandom, $urandom});
               else
                  add_write(lrtc_pkg::CSR_GLOBAL_ROWS,
                            {$urandom, 32'($urandom_range(1, 4096))});
            end
         endcase
         for (int i = 0; i < 57; i++) begin
            r = ($urandom_range(0, 2) == 0) ? 31'($urandom_range(0, 100)) : 31'($urandom);
            c = ($urandom_range(0, 2) == 0) ? 31'($urandom_range(0, 100)) : 31'($urandom);
            pick = $urandom_range(0, 99);
            // keep most columns short, with some full, saturated and empty ones
            if (pick < 70)
               n = 7'($urandom_range(1, 16));
            else if (pick < 80)
               n = 7'($urandom_range(17, 63));
            else if (pick < 88)
               n = 7'd64;
            else if (pick < 94)
               n = 7'($urandom_range(65, 127));
            else
               n = 7'd0;
            add_column(r, c, 6'($urandom_range(0, 63)), n);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (work_q.size() != 0 || req_busy || csr_busy || element_q.size() != 0
             || quiet < SETTLE)
         @(posedge clock);

      if (errors == 0)
         $display("** lcg_random_tile_column_core: PASSED **");
      else
         $display("** lcg_random_tile_column_core: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** lcg_random_tile_column_core: FAILED **");
      $finish;
   end

endmodule

// ===== lcg_random_tile_column_core.f =====
+incdir+sv
sv/lrtc_pkg.sv
sv/lrtc_ctrl.sv
sv/lrtc_dpath.sv
sv/lcg_random_tile_column_core.sv
tb/tb_lcg_random_tile_column_core.sv
